@@ hw/rtl/canonical_huffman_code_encoder_core_defines.svh @@
// assertion macros for the encoder checker
`ifndef CANONICAL_HUFFMAN_CODE_ENCODER_CORE_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CHCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CHCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/chce_pkg.sv @@
`default_nettype none

package chce_pkg;

	localparam int FUNC_W = 2;
	localparam int SYM_W  = 9;
	localparam int LEN_W  = 6;
	localparam int CODE_W = 32;
	localparam int TOT_W  = 9;
	localparam int STAT_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR  = 2'd0,
		FN_LOAD   = 2'd1,
		FN_ENCODE = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK       = 2'd0,
		STS_UNSORTED = 2'd1,
		STS_BAD_LEN  = 2'd2,
		STS_NO_SYM   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic fire;
		logic sweep;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic is_clear;
	} dp_stat_t;

	function automatic logic [CODE_W-1:0] rev_bits(input logic [CODE_W-1:0] v);
		logic [CODE_W-1:0] r;
		for (int i = 0; i < CODE_W; i++) begin
			r[i] = v[CODE_W-1-i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/chce_ctrl.sv @@
`default_nettype none

module chce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire chce_pkg::dp_stat_t   stat,
	output chce_pkg::ctrl_cmd_t       cmd
);

	chce_pkg::state_t state_q;
	chce_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			chce_pkg::ST_SWEEP: begin
				if (stat.sweep_done) begin
					state_d = chce_pkg::ST_IDLE;
				end
			end
			chce_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = chce_pkg::ST_EXEC;
				end
			end
			chce_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = stat.is_clear ? chce_pkg::ST_SWEEP : chce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chce_pkg::ST_SWEEP;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.fire    = 1'b0;
		cmd.sweep   = 1'b0;
		case (state_q)
			chce_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
			end
			chce_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			chce_pkg::ST_EXEC: begin
				cmd.fire = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chce_pkg::ST_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/chce_dp.sv @@
`default_nettype none

module chce_dp #(
	parameter int MAX_CODE_LEN = 32,
	parameter int NUM_SYMBOLS  = 259
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire chce_pkg::ctrl_cmd_t           cmd,
	output chce_pkg::dp_stat_t                 stat,
	input  wire logic [chce_pkg::FUNC_W-1:0]   func,
	input  wire logic [chce_pkg::SYM_W-1:0]    symbol,
	input  wire logic [chce_pkg::LEN_W-1:0]    length_arg,
	output logic      [chce_pkg::CODE_W-1:0]   code_bits,
	output logic      [chce_pkg::LEN_W-1:0]    bit_count,
	output logic      [chce_pkg::TOT_W-1:0]    length_total,
	output logic      [chce_pkg::STAT_W-1:0]   status
);

	localparam int SYM_AW = $clog2(NUM_SYMBOLS);
	localparam int LEN_AW = $clog2(MAX_CODE_LEN + 1);

	logic [chce_pkg::CODE_W-1:0] code_mem [NUM_SYMBOLS];
	logic [chce_pkg::LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
	logic [chce_pkg::TOT_W-1:0]  hist_mem [MAX_CODE_LEN+1];

	chce_pkg::func_t             func_q;
	logic [chce_pkg::SYM_W-1:0]  sym_q;
	logic [chce_pkg::LEN_W-1:0]  len_q;
	logic [chce_pkg::CODE_W-1:0] code_rd_q;
	logic [chce_pkg::LEN_W-1:0]  len_rd_q;
	logic [chce_pkg::TOT_W-1:0]  hist_rd_q;

	logic [chce_pkg::CODE_W-1:0] running_code_q;
	logic [chce_pkg::LEN_W-1:0]  prev_len_q;
	logic [chce_pkg::SYM_W-1:0]  prev_sym_q;
	logic                        any_q;
	logic [SYM_AW-1:0]           cnt_q;

	logic [chce_pkg::CODE_W-1:0] code_q;
	logic [chce_pkg::LEN_W-1:0]  count_q;
	logic [chce_pkg::TOT_W-1:0]  total_q;
	chce_pkg::status_t           status_q;

	logic [SYM_AW-1:0]           rd_sym_addr;
	logic [LEN_AW-1:0]           rd_len_addr;
	logic [SYM_AW-1:0]           wr_sym_addr;
	logic [LEN_AW-1:0]           wr_len_addr;

	logic                        sym_ok;
	logic                        len_ok;
	logic                        unsorted;
	logic                        grow;
	logic [chce_pkg::LEN_W-1:0]  shamt;
	logic [chce_pkg::CODE_W-1:0] code_new;
	logic [chce_pkg::CODE_W-1:0] code_rev;
	logic                        load_ok;
	logic                        load_wr;
	logic                        is_clear;
	logic                        sweep_done;
	logic                        hist_sweep;

	chce_pkg::status_t           res_status;
	logic [chce_pkg::CODE_W-1:0] res_code;
	logic [chce_pkg::LEN_W-1:0]  res_count;
	logic [chce_pkg::TOT_W-1:0]  res_total;

	// out-of-range addresses fold to entry zero, their data is never used
	assign rd_sym_addr = (int'(symbol) < NUM_SYMBOLS) ? symbol[SYM_AW-1:0] : '0;
	assign rd_len_addr = (int'(length_arg) <= MAX_CODE_LEN) ?
		length_arg[LEN_AW-1:0] : '0;

	assign wr_sym_addr = sym_q[SYM_AW-1:0];
	assign wr_len_addr = len_q[LEN_AW-1:0];

	assign is_clear   = (func_q == chce_pkg::FN_CLEAR);
	assign sweep_done = (cnt_q == SYM_AW'(NUM_SYMBOLS - 1));
	assign hist_sweep = cmd.sweep && (int'(cnt_q) <= MAX_CODE_LEN);
	assign stat.sweep_done = sweep_done;
	assign stat.is_clear   = is_clear;

	assign sym_ok   = int'(sym_q) < NUM_SYMBOLS;
	assign len_ok   = (len_q != '0) && (int'(len_q) <= MAX_CODE_LEN);
	assign unsorted = (len_rd_q != '0) || (any_q && ((len_q < prev_len_q) ||
		((len_q == prev_len_q) && (sym_q <= prev_sym_q))));
	assign grow     = any_q && (len_q > prev_len_q);
	assign shamt    = len_q - prev_len_q;
	assign code_new = grow ? (running_code_q << shamt) : running_code_q;
	assign code_rev = chce_pkg::rev_bits(code_new) >>
		(chce_pkg::LEN_W'(chce_pkg::CODE_W) - len_q);

	always_comb begin
		res_status = chce_pkg::STS_OK;
		res_code   = '0;
		res_count  = '0;
		res_total  = '0;
		load_ok    = 1'b0;
		case (func_q)
			chce_pkg::FN_LOAD: begin
				if (!sym_ok) begin
					res_status = chce_pkg::STS_NO_SYM;
				end else if (!len_ok) begin
					res_status = chce_pkg::STS_BAD_LEN;
				end else if (unsorted) begin
					res_status = chce_pkg::STS_UNSORTED;
				end else begin
					load_ok = 1'b1;
				end
			end
			chce_pkg::FN_ENCODE: begin
				if (!sym_ok || (len_rd_q == '0)) begin
					res_status = chce_pkg::STS_NO_SYM;
				end else begin
					res_code  = code_rd_q;
					res_count = len_rd_q;
				end
			end
			chce_pkg::FN_QUERY: begin
				if (int'(len_q) > MAX_CODE_LEN) begin
					res_status = chce_pkg::STS_BAD_LEN;
				end else begin
					res_total = hist_rd_q;
				end
			end
			default: begin
				res_status = chce_pkg::STS_OK;
			end
		endcase
	end

	assign load_wr = cmd.fire && load_ok;

	// transaction capture and registered memory reads
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= chce_pkg::func_t'(func);
			sym_q     <= symbol;
			len_q     <= length_arg;
			code_rd_q <= code_mem[rd_sym_addr];
			len_rd_q  <= len_mem[rd_sym_addr];
			hist_rd_q <= hist_mem[rd_len_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			code_mem[wr_sym_addr] <= code_rev;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			len_mem[cnt_q] <= '0;
		end else if (load_wr) begin
			len_mem[wr_sym_addr] <= len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_sweep) begin
			hist_mem[cnt_q[LEN_AW-1:0]] <= '0;
		end else if (load_wr) begin
			hist_mem[wr_len_addr] <= (hist_rd_q == '1) ? hist_rd_q : hist_rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			code_q   <= res_code;
			count_q  <= res_count;
			total_q  <= res_total;
			status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_code_q <= '0;
			prev_len_q     <= '0;
			prev_sym_q     <= '0;
			any_q          <= 1'b0;
			cnt_q          <= '0;
		end else begin
			if (cmd.sweep) begin
				cnt_q <= sweep_done ? '0 : cnt_q + 1'b1;
			end
			if (cmd.fire && is_clear) begin
				running_code_q <= '0;
				prev_len_q     <= '0;
				prev_sym_q     <= '0;
				any_q          <= 1'b0;
			end else if (load_wr) begin
				running_code_q <= code_new + 1'b1;
				prev_len_q     <= len_q;
				prev_sym_q     <= sym_q;
				any_q          <= 1'b1;
			end
		end
	end

	assign code_bits    = code_q;
	assign bit_count    = count_q;
	assign length_total = total_q;
	assign status       = status_q;

endmodule

`default_nettype wire

@@ hw/rtl/canonical_huffman_code_encoder_core.sv @@
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     func, symbol, length_arg
// out      output     out_valid / out_ready   code_bits, bit_count, length_total, status
//
// every transaction is accepted in the idle state, then does the table read-modify-write and result in the exec state
// a clear transaction adds a sweep over the length and histogram memories
// after reset the same sweep runs before the first accept
// results sit in an output register; a new transaction is accepted while one waits
// the update cycle waits only while the output register is full and not taken
`default_nettype none

module canonical_huffman_code_encoder_core #(
	parameter int MAX_CODE_LEN = 32,
	parameter int NUM_SYMBOLS  = 259
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [chce_pkg::FUNC_W-1:0]   func,
	input  wire logic [chce_pkg::SYM_W-1:0]    symbol,
	input  wire logic [chce_pkg::LEN_W-1:0]    length_arg,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [chce_pkg::CODE_W-1:0]   code_bits,
	output logic      [chce_pkg::LEN_W-1:0]    bit_count,
	output logic      [chce_pkg::TOT_W-1:0]    length_total,
	output logic      [chce_pkg::STAT_W-1:0]   status
);

	chce_pkg::ctrl_cmd_t cmd;
	chce_pkg::dp_stat_t  stat;

	chce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	chce_dp #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.symbol       (symbol),
		.length_arg   (length_arg),
		.code_bits    (code_bits),
		.bit_count    (bit_count),
		.length_total (length_total),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ hw/rtl/chce_checker.sv @@
`default_nettype none
`include "canonical_huffman_code_encoder_core_defines.svh"

module chce_checker #(
	parameter int MAX_CODE_LEN = 32
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [chce_pkg::CODE_W-1:0]   code_bits,
	input wire logic [chce_pkg::LEN_W-1:0]    bit_count,
	input wire logic [chce_pkg::TOT_W-1:0]    length_total,
	input wire logic [chce_pkg::STAT_W-1:0]   status
);

	logic in_fire;
	logic err_out;
	logic code_out;

	assign in_fire  = in_valid && in_ready;
	assign err_out  = out_valid && (status != chce_pkg::STS_OK);
	assign code_out = out_valid && (bit_count != '0);

	`CHCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_bits) && $stable(bit_count) && $stable(length_total) && $stable(status), "stalled result changed")
	`CHCE_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready, "accepted a transaction while one is in work")
	`CHCE_ASSERT_NOW(a_err_zero, err_out, (code_bits == '0) && (bit_count == '0) && (length_total == '0), "error result carries data")
	`CHCE_ASSERT_NOW(a_code_ok, code_out, (status == chce_pkg::STS_OK) && (length_total == '0) && (int'(bit_count) <= MAX_CODE_LEN), "bad encode result")
	`CHCE_ASSERT_NOW(a_code_width, out_valid, (code_bits >> bit_count) == '0, "code bits beyond bit count")

endmodule

bind canonical_huffman_code_encoder_core chce_checker #(
	.MAX_CODE_LEN (MAX_CODE_LEN)
) u_chce_checker (.*);

`default_nettype wire
